// File: sv/dstq_pkg.sv
`default_nettype none

package dstq_pkg;

    // Table geometry
    localparam int DEPTH       = 16;
    localparam int TIME_BITS   = 48;
    localparam int DELAY_BITS  = 32;
    localparam int TAG_BITS    = 16;
    localparam int MAX_RESULTS = 16;

    localparam int AW = $clog2(DEPTH);            // slot address
    localparam int CW = $clog2(DEPTH + 1);        // entry count / logical index
    localparam int NW = $clog2(MAX_RESULTS + 1);  // fired-per-poll count

    localparam int ENTRY_BITS = TIME_BITS + TAG_BITS;

    typedef enum logic {
        KIND_SCHEDULE = 1'b0,
        KIND_POLL     = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_FIRED    = 2'd0,
        STATUS_ACCEPTED = 2'd1,
        STATUS_REJECTED = 2'd2,
        STATUS_NONE     = 2'd3
    } t_status;

    typedef struct packed {
        t_kind                 kind;
        logic [TIME_BITS-1:0]  current_time;
        logic [DELAY_BITS-1:0] delay_ms;
        logic [TAG_BITS-1:0]   call_tag;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [TAG_BITS-1:0] fired_tag;
        logic                last;
    } t_res;

    typedef struct packed {
        logic [TIME_BITS-1:0] due;
        logic [TAG_BITS-1:0]  tag;
    } t_entry;

endpackage

`default_nettype wire

// File: sv/dstq_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data
module dstq_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/deadline_sorted_timer_queue_unit.sv
`default_nettype none

// Channel   | Ports                     | Handshake
// ----------+---------------------------+-------------------------------------
// request   | start, busy, i_req        | taken on a clock edge with start & !busy
// result    | o_res_valid, o_res        | one cycle per result, no back-pressure
//
// Entries live in one RAM as a ring (head pointer + count), sorted by due time.
// Schedule: rejected when full, else entries due at or after the new one are moved
// up, one RAM read and one write per step of the tail-to-head shift walk.
// Poll: one RAM read per entry fired; a fired tag is held pending until the
// next entry is judged, so the last flag is known when it goes out.
// Synchronous reset empties the table; results cannot be stalled.

module deadline_sorted_timer_queue_unit
    import dstq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_req i_req,
    output logic      busy,
    output logic      o_res_valid,
    output t_res      o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_INS,
        ST_POLL
    } t_state;

    t_state               r_state,    n_state;
    logic [AW-1:0]        r_base,     n_base;
    logic [CW-1:0]        r_cnt,      n_cnt;
    logic [CW-1:0]        r_idx,      n_idx;
    logic [NW-1:0]        r_n,        n_n;
    logic [TIME_BITS-1:0] r_due,      n_due;
    logic [TIME_BITS-1:0] r_now,      n_now;
    logic [TAG_BITS-1:0]  r_tag,      n_tag;
    logic                 r_pend_v,   n_pend_v;
    logic [TAG_BITS-1:0]  r_pend_tag, n_pend_tag;
    logic                 r_out_v,    n_out_v;
    t_res                 r_out,      n_out;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    t_entry                mem_wdata;
    logic [ENTRY_BITS-1:0] mem_rdata;
    t_entry                rd_entry;
    logic [TIME_BITS:0]    due_sum;
    logic [TIME_BITS-1:0]  due_sat;
    logic                  hit;

    // Logical index -> ring slot
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(idx);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    dstq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_entry = t_entry'(mem_rdata);

    // Due time, saturating at the top of the time range
    assign due_sum = (TIME_BITS+1)'(i_req.current_time) + (TIME_BITS+1)'(i_req.delay_ms);
    assign due_sat = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];

    // Head entry of a poll walk is due and the per-poll result limit is not reached
    assign hit = (r_cnt != '0) && (r_n < NW'(MAX_RESULTS)) && (rd_entry.due <= r_now);

    // Sequencer next-state and RAM control
    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_n        = r_n;
        n_due      = r_due;
        n_now      = r_now;
        n_tag      = r_tag;
        n_pend_v   = r_pend_v;
        n_pend_tag = r_pend_tag;
        n_out_v    = 1'b0;
        n_out      = r_out;
        mem_we     = 1'b0;
        mem_waddr  = slot(r_base, r_idx);
        mem_wdata  = '{due: r_due, tag: r_tag};
        mem_raddr  = r_base;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_req.kind == KIND_SCHEDULE) begin
                        if (r_cnt == CW'(DEPTH)) begin
                            n_out_v = 1'b1;
                            n_out   = '{status: STATUS_REJECTED, fired_tag: '0, last: 1'b1};
                        end else begin
                            n_due     = due_sat;
                            n_tag     = i_req.call_tag;
                            n_idx     = r_cnt;
                            mem_raddr = slot(r_base, r_cnt - CW'(1));
                            n_state   = (r_cnt == '0) ? ST_INS : ST_SHIFT;
                        end
                    end else begin
                        n_now    = i_req.current_time;
                        n_n      = '0;
                        n_pend_v = 1'b0;
                        n_state  = ST_POLL;
                    end
                end
            end

            // Walk from the tail: move entries not earlier than the new one up
            ST_SHIFT: begin
                mem_we = 1'b1;
                if (rd_entry.due >= r_due) begin
                    mem_wdata = rd_entry;
                    n_idx     = r_idx - CW'(1);
                    mem_raddr = slot(r_base, r_idx - CW'(2));
                    if (r_idx == CW'(1)) begin
                        n_state = ST_INS;
                    end
                end else begin
                    n_cnt   = r_cnt + CW'(1);
                    n_out_v = 1'b1;
                    n_out   = '{status: STATUS_ACCEPTED, fired_tag: '0, last: 1'b1};
                    n_state = ST_IDLE;
                end
            end

            // New entry goes to the head
            ST_INS: begin
                mem_we  = 1'b1;
                n_cnt   = r_cnt + CW'(1);
                n_out_v = 1'b1;
                n_out   = '{status: STATUS_ACCEPTED, fired_tag: '0, last: 1'b1};
                n_state = ST_IDLE;
            end

            // Pop due entries from the head; previous tag goes out once next is judged
            ST_POLL: begin
                if (hit) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out   = '{status: STATUS_FIRED, fired_tag: r_pend_tag, last: 1'b0};
                    end
                    n_pend_v   = 1'b1;
                    n_pend_tag = rd_entry.tag;
                    n_base     = slot(r_base, CW'(1));
                    mem_raddr  = slot(r_base, CW'(1));
                    n_cnt      = r_cnt - CW'(1);
                    n_n        = r_n + NW'(1);
                end else begin
                    n_out_v = 1'b1;
                    if (r_pend_v) begin
                        n_out = '{status: STATUS_FIRED, fired_tag: r_pend_tag, last: 1'b1};
                    end else begin
                        n_out = '{status: STATUS_NONE, fired_tag: '0, last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_base   <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_due      <= n_due;
        r_now      <= n_now;
        r_tag      <= n_tag;
        r_pend_tag <= n_pend_tag;
        r_out      <= n_out;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// File: tb/sv/dstq_result_checker.sv
`timescale 1ns / 100ps

// Watches the request and result channels of the timer queue, keeps its own
// copy of the sorted table and checks every result against the oldest one due.
module dstq_result_checker
    import dstq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_req        i_req,
    input  logic        i_res_valid,
    input  t_res        i_res,
    output int unsigned o_error_count,
    output int unsigned o_pending_count,
    output int unsigned o_request_count,
    output int unsigned o_fired_count,
    output int unsigned o_rejected_count,
    output int unsigned o_none_count
);

    localparam int REPORT_LIMIT = 10;

    // Shadow of the timer table
    logic [TIME_BITS-1:0] shadow_due [DEPTH];
    logic [TAG_BITS-1:0]  shadow_tag [DEPTH];
    int                   shadow_count;

    // Results predicted but not yet seen, oldest first
    t_res        awaited_results [$];
    t_res        oldest_result;
    int unsigned error_count;
    int unsigned request_count;
    int unsigned fired_count;
    int unsigned rejected_count;
    int unsigned none_count;

    function automatic t_res make_result(t_status status, logic [TAG_BITS-1:0] tag,
                                         logic last);
        t_res r;
        r.status    = status;
        r.fired_tag = tag;
        r.last      = last;
        return r;
    endfunction

    // Apply one request to the shadow table and queue the results it yields
    task automatic apply_timer_request(input t_req r);
        logic [TIME_BITS:0]   sum;
        logic [TIME_BITS-1:0] due;
        int                   pos;
        int                   n;
        if (r.kind == KIND_SCHEDULE) begin
            if (shadow_count >= DEPTH) begin
                awaited_results.push_back(make_result(STATUS_REJECTED, '0, 1'b1));
            end else begin
                // due time saturates at the all-ones time
                sum = r.current_time;
                sum = sum + r.delay_ms;
                due = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                // insert ahead of the first entry not earlier than the new one
                pos = 0;
                while (pos < shadow_count && shadow_due[pos] < due)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_due[i] = shadow_due[i-1];
                    shadow_tag[i] = shadow_tag[i-1];
                end
                shadow_due[pos] = due;
                shadow_tag[pos] = r.call_tag;
                shadow_count++;
                awaited_results.push_back(make_result(STATUS_ACCEPTED, '0, 1'b1));
            end
        end else begin
            n = 0;
            while (n < shadow_count && n < MAX_RESULTS && shadow_due[n] <= r.current_time)
                n++;
            if (n == 0) begin
                awaited_results.push_back(make_result(STATUS_NONE, '0, 1'b1));
            end else begin
                for (int i = 0; i < n; i++)
                    awaited_results.push_back(make_result(STATUS_FIRED, shadow_tag[i],
                                                          (i + 1 == n)));
                for (int i = n; i < shadow_count; i++) begin
                    shadow_due[i-n] = shadow_due[i];
                    shadow_tag[i-n] = shadow_tag[i];
                end
                shadow_count -= n;
            end
        end
    endtask

    initial begin
        shadow_count   = 0;
        error_count    = 0;
        request_count  = 0;
        fired_count    = 0;
        rejected_count = 0;
        none_count     = 0;
    end

    // Results are compared before a request taken on the same edge is applied
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            if (i_res_valid) begin
                if (awaited_results.size() == 0) begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: result with nothing awaited: status %0d tag %h last %b",
                                 $realtime, i_res.status, i_res.fired_tag, i_res.last);
                    error_count++;
                end else begin
                    oldest_result = awaited_results.pop_front();
                    if (i_res.status !== oldest_result.status
                        || i_res.fired_tag !== oldest_result.fired_tag
                        || i_res.last !== oldest_result.last) begin
                        if (error_count < REPORT_LIMIT)
                            $display("%0t: result mismatch: want status %0d tag %h last %b, got status %0d tag %h last %b",
                                     $realtime, oldest_result.status,
                                     oldest_result.fired_tag, oldest_result.last,
                                     i_res.status, i_res.fired_tag, i_res.last);
                        error_count++;
                    end
                    case (oldest_result.status)
                        STATUS_FIRED:    fired_count++;
                        STATUS_REJECTED: rejected_count++;
                        STATUS_NONE:     none_count++;
                        default: ;
                    endcase
                end
            end
            if (i_start && !i_busy) begin
                request_count++;
                apply_timer_request(i_req);
            end
        end
        o_error_count    <= error_count;
        o_pending_count  <= awaited_results.size();
        o_request_count  <= request_count;
        o_fired_count    <= fired_count;
        o_rejected_count <= rejected_count;
        o_none_count     <= none_count;
    end

endmodule

// File: tb/sv/deadline_sorted_timer_queue_unit_test.sv
`timescale 1ns / 100ps

module deadline_sorted_timer_queue_unit_test;
    import dstq_pkg::*;

    localparam int RANDOM_REQUESTS = 450;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 40;

    localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
    localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_res_valid;
    t_res o_res;

    int unsigned error_count;
    int unsigned pending_count;
    int unsigned request_count;
    int unsigned fired_count;
    int unsigned rejected_count;
    int unsigned none_count;
    int unsigned cycle_count = 0;

    // Random-phase state
    logic [TIME_BITS-1:0] clock_ms;
    bit                   fill_heavy   = 1'b0;
    bit                   back_to_back = 1'b0;

    always #5 i_clk = ~i_clk;

    deadline_sorted_timer_queue_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    dstq_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_req           (i_req),
        .i_res_valid     (o_res_valid),
        .i_res           (o_res),
        .o_error_count   (error_count),
        .o_pending_count (pending_count),
        .o_request_count (request_count),
        .o_fired_count   (fired_count),
        .o_rejected_count(rejected_count),
        .o_none_count    (none_count)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("deadline_sorted_timer_queue_unit_test: errors");
            $finish;
        end
    end

    function automatic logic [TIME_BITS-1:0] any_time();
        return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
    endfunction

    // Issue one request after a random idle gap (none when back to back) and hold it until taken
    task automatic send_request(input t_kind kind, input logic [TIME_BITS-1:0] now,
                                input logic [DELAY_BITS-1:0] delay,
                                input logic [TAG_BITS-1:0] tag);
        int unsigned gap;
        t_req        r;
        gap = back_to_back ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        r.kind         = kind;
        r.current_time = now;
        r.delay_ms     = delay;
        r.call_tag     = tag;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        logic [TIME_BITS-1:0]  now;
        logic [DELAY_BITS-1:0] delay;
        t_kind                 kind;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: empty poll, time and delay extremes, saturation, equal due times
        send_request(KIND_POLL,     '0,           '0,        '0);
        send_request(KIND_SCHEDULE, '0,           '0,        16'h0000);
        send_request(KIND_SCHEDULE, TIME_MAX,     DELAY_MAX, 16'hFFFF);
        send_request(KIND_SCHEDULE, TIME_MAX - 5, 32'd10,    16'h1234);
        send_request(KIND_SCHEDULE, 48'd100,      32'd50,    16'hA5A5);
        send_request(KIND_SCHEDULE, 48'd120,      32'd30,    16'h5A5A);
        send_request(KIND_POLL,     48'd149,      '0,        '0);
        send_request(KIND_POLL,     48'd150,      '0,        '0);
        send_request(KIND_POLL,     TIME_MAX,     '0,        '0);

        // Directed: fill the table, overflow it, then drain it in one poll
        for (int i = 0; i < DEPTH; i++)
            send_request(KIND_SCHEDULE, 48'd1000, 32'((i * 37) % 50),
                         16'($urandom_range(0, 16'hFFFF)));
        send_request(KIND_SCHEDULE, 48'd1000, 32'd1, 16'hBEEF);
        send_request(KIND_POLL,     TIME_MAX, '0,    '0);

        // Random: a mostly advancing clock, with fill-heavy and drain-heavy phases
        clock_ms = 48'd2000;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if ($urandom_range(0, 39) == 0)
                fill_heavy = !fill_heavy;
            if ($urandom_range(0, 29) == 0)
                back_to_back = !back_to_back;
            if ($urandom_range(0, 49) == 0)
                clock_ms = $urandom_range(0, 2) == 0 ? TIME_MAX - $urandom_range(0, 5000)
                                                     : any_time();
            clock_ms = clock_ms + $urandom_range(0, 40);

            // occasional out-of-order time as noise
            now = ($urandom_range(0, 19) == 0) ? any_time() : clock_ms;

            kind = ($urandom_range(0, 99) < (fill_heavy ? 80 : 35)) ? KIND_SCHEDULE
                                                                    : KIND_POLL;
            case ($urandom_range(0, 9))
                0:       delay = '0;
                1:       delay = $urandom;
                2:       delay = DELAY_MAX;
                default: delay = $urandom_range(0, 400);
            endcase
            send_request(kind, now, delay, 16'($urandom_range(0, 16'hFFFF)));
        end
        @(negedge i_clk) start <= 1'b0;

        // Drain outstanding results, then allow for any late extras
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests taken; %0d calls fired, %0d rejected on a full table, %0d polls with nothing due",
                 request_count, fired_count, rejected_count, none_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("deadline_sorted_timer_queue_unit_test: clean");
        end else begin
            $display("deadline_sorted_timer_queue_unit_test: errors");
        end
        $finish;
    end

endmodule

// File: deadline_sorted_timer_queue_unit.f
sv/dstq_pkg.sv
sv/dstq_ram.sv
sv/deadline_sorted_timer_queue_unit.sv
tb/sv/dstq_result_checker.sv
tb/sv/deadline_sorted_timer_queue_unit_test.sv
